/* design/cts_pkg.sv */
`timescale 1ns / 1ps
package cts_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       at_end;
  } in_beat_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_beat_t;

  typedef enum logic [32:0] {
    M_IDLE   = 33'h0_0000_0001,
    M_SPACE  = 33'h0_0000_0002,
    M_IDENT  = 33'h0_0000_0004,
    M_ZERO   = 33'h0_0000_0008,
    M_INT    = 33'h0_0000_0010,
    M_FRAC   = 33'h0_0000_0020,
    M_EXP0   = 33'h0_0000_0040,
    M_EXPS   = 33'h0_0000_0080,
    M_EXPD   = 33'h0_0000_0100,
    M_HEX0   = 33'h0_0000_0200,
    M_HEXD   = 33'h0_0000_0400,
    M_EQ     = 33'h0_0000_0800,
    M_PLUS   = 33'h0_0000_1000,
    M_MINUS  = 33'h0_0000_2000,
    M_AST    = 33'h0_0000_4000,
    M_PCT    = 33'h0_0000_8000,
    M_LT     = 33'h0_0001_0000,
    M_GT     = 33'h0_0002_0000,
    M_EXCL   = 33'h0_0004_0000,
    M_CARET  = 33'h0_0008_0000,
    M_AMP    = 33'h0_0010_0000,
    M_PIPE   = 33'h0_0020_0000,
    M_CARET2 = 33'h0_0040_0000,
    M_AMP2   = 33'h0_0080_0000,
    M_PIPE2  = 33'h0_0100_0000,
    M_SLASH  = 33'h0_0200_0000,
    M_LINE   = 33'h0_0400_0000,
    M_BLOCK  = 33'h0_0800_0000,
    M_BSTAR  = 33'h0_1000_0000,
    M_SQ     = 33'h0_2000_0000,
    M_SQE    = 33'h0_4000_0000,
    M_DQ     = 33'h0_8000_0000,
    M_DQE    = 33'h1_0000_0000
  } mode_t;

  localparam logic [6:0] K_ERR   = 7'd0;
  localparam logic [6:0] K_EQEQ  = 7'd0;
  localparam logic [6:0] K_IDENT = 7'd73;
  localparam logic [6:0] K_END   = 7'd74;
  localparam logic [6:0] K_UI    = 7'd48;
  localparam logic [6:0] K_FP    = 7'd49;
  localparam logic [6:0] K_WS    = 7'd50;
  localparam logic [6:0] K_KW0   = 7'd51;
  localparam logic [6:0] K_LCOM  = 7'd12;
  localparam logic [6:0] K_BCOM  = 7'd11;
  localparam logic [6:0] K_SLASH = 7'd13;
  localparam logic [6:0] K_SLEQ  = 7'd10;
  localparam logic [6:0] K_SQS   = 7'd43;
  localparam logic [6:0] K_DQS   = 7'd44;
  localparam logic [6:0] K_LBRACK = 7'd28;
  localparam logic [6:0] K_RBRACK = 7'd29;
  localparam logic [6:0] K_LBRACE = 7'd30;
  localparam logic [6:0] K_RBRACE = 7'd31;
  localparam logic [6:0] K_LPAREN = 7'd32;
  localparam logic [6:0] K_RPAREN = 7'd33;
  localparam logic [6:0] K_DOT    = 7'd34;
  localparam logic [6:0] K_SEMI   = 7'd35;
  localparam logic [6:0] K_TILDE  = 7'd40;
  localparam logic [6:0] K_COMMA  = 7'd45;
  localparam logic [6:0] K_QUEST  = 7'd46;
  localparam logic [6:0] K_COLON  = 7'd47;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_COMMENT = 3'd1;
  localparam logic [2:0] E_STRING  = 3'd2;
  localparam logic [2:0] E_HEX     = 3'd3;
  localparam logic [2:0] E_EXP     = 3'd4;
  localparam logic [2:0] E_CHAR    = 3'd5;

  localparam int NUM_KW = 22;
  localparam int KW_MAX = 8;

  // keywords, first character in the low byte
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h6e69, 64'h6f69, 64'h6669, 64'h6f64, 64'h726f66, 64'h726176,
    64'h65736163, 64'h65736c65, 64'h65757274, 64'h7361696c61,
    64'h6b61657262, 64'h74736e6f63, 64'h65736c6166, 64'h656c696877,
    64'h746375727473, 64'h686374697773, 64'h74726f706572, 64'h6e7275746572,
    64'h746c7561666564, 64'h6e6f6974636e7566, 64'h726f74617265706f,
    64'h65756e69746e6f63
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd8, 4'd8, 4'd8
  };

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b[7];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h0a || b == 8'h0d || b == 8'h09 || b == 8'h0b;
  endfunction

  // operator modes: doubling byte, double kind, '=' kind, plain kind
  function automatic logic [7:0] op_dbl(input mode_t m);
    unique case (m)
      M_PLUS:  return "+";
      M_MINUS: return "-";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [6:0] op_dblk(input mode_t m);
    return (m == M_PLUS) ? 7'd3 : 7'd6;
  endfunction

  function automatic logic [6:0] op_eqk(input mode_t m);
    unique case (m)
      M_EQ:    return K_EQEQ;
      M_PLUS:  return 7'd2;
      M_MINUS: return 7'd5;
      M_AST:   return 7'd8;
      M_PCT:   return 7'd14;
      M_LT:    return 7'd36;
      M_GT:    return 7'd38;
      M_EXCL:  return 7'd41;
      M_CARET: return 7'd18;
      M_AMP:   return 7'd22;
      M_PIPE:  return 7'd26;
      M_CARET2: return 7'd16;
      M_AMP2:  return 7'd20;
      M_PIPE2: return 7'd24;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] op_plain(input mode_t m);
    unique case (m)
      M_EQ:    return 7'd1;
      M_PLUS:  return 7'd4;
      M_MINUS: return 7'd7;
      M_AST:   return 7'd9;
      M_PCT:   return 7'd15;
      M_LT:    return 7'd37;
      M_GT:    return 7'd39;
      M_EXCL:  return 7'd42;
      M_CARET: return 7'd19;
      M_AMP:   return 7'd23;
      M_PIPE:  return 7'd27;
      M_CARET2: return 7'd17;
      M_AMP2:  return 7'd21;
      M_PIPE2: return 7'd25;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [7:0] tr_ch(input mode_t m);
    unique case (m)
      M_CARET: return "^";
      M_AMP:   return "&";
      default: return "|";
    endcase
  endfunction

  function automatic mode_t tr_next(input mode_t m);
    unique case (m)
      M_CARET: return M_CARET2;
      M_AMP:   return M_AMP2;
      default: return M_PIPE2;
    endcase
  endfunction

endpackage

/* design/c_like_token_scanner.sv */
`timescale 1ns / 1ps
// Streaming lexer: one source byte per beat, one beat accepted per cycle while the
// output side keeps up. Each beat yields zero, one or two tokens; they sit in a
// two-entry result buffer and leave one per cycle while out_ready is high; a beat
// closing one token and opening another fills both. in_ready drops only when the
// buffer cannot take the next beat's worst case. The scan itself is one registered
// pass: keyword match over the stored prefix is a parallel compare at close time.
module c_like_token_scanner #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LENGTH_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cts_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cts_pkg::out_beat_t out_data
);

  localparam int KB = KEYWORD_CHARS * 8;
  localparam int KIW = $clog2(KEYWORD_CHARS);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  cts_pkg::mode_t          mode_r, mode_nxt;
  logic [KB-1:0]           kw_r, kw_nxt;
  logic [LENGTH_BITS-1:0]  len_r, len_nxt;
  logic [31:0]             start_r, start_nxt;
  logic [31:0]             pos_r, pos_nxt;
  logic                    err_r, err_nxt;

  cts_pkg::out_beat_t      buf_r [2];
  cts_pkg::out_beat_t      res0, res1;
  logic [1:0]              cnt_r, cnt_nxt;
  logic [1:0]              nres;
  logic                    in_fire, out_fire;

  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = cnt_r != 2'd0;
  assign out_fire  = out_valid && out_ready;
  assign out_data  = buf_r[0];

  // scan
  always_comb begin
    logic [7:0]             b;
    logic                   taken, e, is_kw;
    logic [6:0]             kind, imm;
    logic [LENGTH_BITS-1:0] gl;
    logic [15:0]            ol, og;
    cts_pkg::out_beat_t     r [2];
    logic [1:0]             n;
    b = in_data.data_byte;
    mode_nxt = mode_r;
    kw_nxt = kw_r;
    len_nxt = len_r;
    start_nxt = start_r;
    pos_nxt = pos_r;
    err_nxt = err_r;
    n = 2'd0;
    r[0] = '0;
    r[1] = '0;
    taken = 1'b0;
    imm = cts_pkg::K_ERR;
    e = (b == "e" || b == "E");
    gl = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
    ol = (LENGTH_BITS > 16 && len_r > LENGTH_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(len_r);
    og = (LENGTH_BITS > 16 && gl > LENGTH_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(gl);
    kind = cts_pkg::K_IDENT;
    for (int i = cts_pkg::NUM_KW - 1; i >= 0; i--) begin
      is_kw = (len_r == LENGTH_BITS'(cts_pkg::KW_LEN[i]));
      for (int j = 0; j < cts_pkg::KW_MAX; j++)
        if (j < cts_pkg::KW_LEN[i] && j < KEYWORD_CHARS)
          is_kw = is_kw && (kw_r[j*8 +: 8] == cts_pkg::KW_TEXT[i][j*8 +: 8]);
      if (is_kw && len_r <= LENGTH_BITS'(KEYWORD_CHARS)) kind = cts_pkg::K_KW0 + 7'(i);
    end
    if (in_data.at_end) begin
      if (!err_r) begin
        n = 2'd1;
        r[0].token_start = start_r;
        r[0].token_length = ol;
        priority case (mode_r)
          cts_pkg::M_IDLE: n = 2'd0;
          cts_pkg::M_SPACE: r[0].token_kind = cts_pkg::K_WS;
          cts_pkg::M_IDENT: r[0].token_kind = kind;
          cts_pkg::M_ZERO, cts_pkg::M_INT, cts_pkg::M_HEXD:
            r[0].token_kind = cts_pkg::K_UI;
          cts_pkg::M_FRAC, cts_pkg::M_EXPD: r[0].token_kind = cts_pkg::K_FP;
          cts_pkg::M_EXP0, cts_pkg::M_EXPS: r[0].error_code = cts_pkg::E_EXP;
          cts_pkg::M_HEX0: r[0].error_code = cts_pkg::E_HEX;
          cts_pkg::M_SLASH: r[0].token_kind = cts_pkg::K_SLASH;
          cts_pkg::M_LINE: r[0].token_kind = cts_pkg::K_LCOM;
          cts_pkg::M_BLOCK, cts_pkg::M_BSTAR: r[0].error_code = cts_pkg::E_COMMENT;
          cts_pkg::M_SQ, cts_pkg::M_SQE, cts_pkg::M_DQ, cts_pkg::M_DQE:
            r[0].error_code = cts_pkg::E_STRING;
          default: r[0].token_kind = cts_pkg::op_plain(mode_r);
        endcase
      end
      r[n[0]].token_kind = cts_pkg::K_END;
      r[n[0]].token_start = pos_r;
      r[n[0]].token_length = '0;
      r[n[0]].error_code = cts_pkg::E_NONE;
      n = n + 2'd1;
      pos_nxt = '0;
      err_nxt = 1'b0;
      mode_nxt = cts_pkg::M_IDLE;
    end else begin
      pos_nxt = pos_r + 32'd1;
      if (!err_r) begin
        // close or extend the open token
        r[0].token_start = start_r;
        r[0].token_length = ol;
        taken = 1'b1;
        priority case (mode_r)
          cts_pkg::M_IDLE: taken = 1'b0;
          cts_pkg::M_SPACE:
            if (cts_pkg::is_space(b)) len_nxt = gl;
            else begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_WS; end
          cts_pkg::M_IDENT:
            if (cts_pkg::is_alpha(b) || cts_pkg::is_digit(b)) begin
              if (len_r < LENGTH_BITS'(KEYWORD_CHARS)) kw_nxt[len_r[KIW-1:0]*8 +: 8] = b;
              len_nxt = gl;
            end else begin taken = 1'b0; n = 2'd1; r[0].token_kind = kind; end
          cts_pkg::M_ZERO, cts_pkg::M_INT:
            if (mode_r == cts_pkg::M_ZERO && (b == "x" || b == "X")) begin
              len_nxt = gl; mode_nxt = cts_pkg::M_HEX0;
            end else if (cts_pkg::is_digit(b)) begin
              len_nxt = gl; mode_nxt = cts_pkg::M_INT;
            end else if (b == ".") begin
              len_nxt = gl; mode_nxt = cts_pkg::M_FRAC;
            end else if (e) begin
              len_nxt = gl; mode_nxt = cts_pkg::M_EXP0;
            end else begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_UI; end
          cts_pkg::M_FRAC:
            if (cts_pkg::is_digit(b)) len_nxt = gl;
            else if (e) begin len_nxt = gl; mode_nxt = cts_pkg::M_EXP0; end
            else begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_FP; end
          cts_pkg::M_EXP0, cts_pkg::M_EXPS:
            if (mode_r == cts_pkg::M_EXP0 && (b == "+" || b == "-")) begin
              len_nxt = gl; mode_nxt = cts_pkg::M_EXPS;
            end else if (cts_pkg::is_digit(b)) begin
              len_nxt = gl; mode_nxt = cts_pkg::M_EXPD;
            end else begin
              n = 2'd1; r[0].token_length = og;
              r[0].error_code = cts_pkg::E_EXP; err_nxt = 1'b1;
            end
          cts_pkg::M_EXPD:
            if (cts_pkg::is_digit(b)) len_nxt = gl;
            else begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_FP; end
          cts_pkg::M_HEX0:
            if (cts_pkg::is_hex(b)) begin len_nxt = gl; mode_nxt = cts_pkg::M_HEXD; end
            else begin
              n = 2'd1; r[0].token_length = og;
              r[0].error_code = cts_pkg::E_HEX; err_nxt = 1'b1;
            end
          cts_pkg::M_HEXD:
            if (cts_pkg::is_hex(b)) len_nxt = gl;
            else begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_UI; end
          cts_pkg::M_SLASH:
            if (b == "=") begin
              n = 2'd1; r[0].token_length = og; r[0].token_kind = cts_pkg::K_SLEQ;
            end else if (b == "*") begin len_nxt = gl; mode_nxt = cts_pkg::M_BLOCK; end
            else if (b == "/") begin len_nxt = gl; mode_nxt = cts_pkg::M_LINE; end
            else begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_SLASH; end
          cts_pkg::M_LINE:
            if (b == 8'h0a) begin taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::K_LCOM; end
            else len_nxt = gl;
          cts_pkg::M_BLOCK: begin
            len_nxt = gl;
            if (b == "*") mode_nxt = cts_pkg::M_BSTAR;
          end
          cts_pkg::M_BSTAR:
            if (b == "/") begin
              n = 2'd1; r[0].token_length = og; r[0].token_kind = cts_pkg::K_BCOM;
            end else begin
              len_nxt = gl;
              mode_nxt = (b == "*") ? cts_pkg::M_BSTAR : cts_pkg::M_BLOCK;
            end
          cts_pkg::M_SQ, cts_pkg::M_DQ:
            if (b == 8'h5c) begin
              len_nxt = gl;
              mode_nxt = (mode_r == cts_pkg::M_SQ) ? cts_pkg::M_SQE : cts_pkg::M_DQE;
            end else if (b == ((mode_r == cts_pkg::M_SQ) ? 8'h27 : 8'h22)) begin
              n = 2'd1; r[0].token_length = og;
              r[0].token_kind = (mode_r == cts_pkg::M_SQ) ? cts_pkg::K_SQS : cts_pkg::K_DQS;
            end else len_nxt = gl;
          cts_pkg::M_SQE: begin len_nxt = gl; mode_nxt = cts_pkg::M_SQ; end
          cts_pkg::M_DQE: begin len_nxt = gl; mode_nxt = cts_pkg::M_DQ; end
          cts_pkg::M_CARET, cts_pkg::M_AMP, cts_pkg::M_PIPE:
            if (b == cts_pkg::tr_ch(mode_r)) begin
              len_nxt = gl; mode_nxt = cts_pkg::tr_next(mode_r);
            end else if (b == "=") begin
              n = 2'd1; r[0].token_length = og; r[0].token_kind = cts_pkg::op_eqk(mode_r);
            end else begin
              taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::op_plain(mode_r);
            end
          default:
            if (cts_pkg::op_dbl(mode_r) != 8'd0 && b == cts_pkg::op_dbl(mode_r)) begin
              n = 2'd1; r[0].token_length = og; r[0].token_kind = cts_pkg::op_dblk(mode_r);
            end else if (b == "=") begin
              n = 2'd1; r[0].token_length = og; r[0].token_kind = cts_pkg::op_eqk(mode_r);
            end else begin
              taken = 1'b0; n = 2'd1; r[0].token_kind = cts_pkg::op_plain(mode_r);
            end
        endcase
        if (taken && n != 2'd0) mode_nxt = cts_pkg::M_IDLE;
        // byte opens a new token
        if (!taken) begin
          start_nxt = pos_r;
          len_nxt = LENGTH_BITS'(1);
          mode_nxt = cts_pkg::M_IDLE;
          priority if (cts_pkg::is_space(b)) mode_nxt = cts_pkg::M_SPACE;
          else if (cts_pkg::is_alpha(b)) begin
            mode_nxt = cts_pkg::M_IDENT; kw_nxt[7:0] = b;
          end else if (cts_pkg::is_digit(b))
            mode_nxt = (b == "0") ? cts_pkg::M_ZERO : cts_pkg::M_INT;
          else begin
            unique case (b)
              "=": mode_nxt = cts_pkg::M_EQ;
              "+": mode_nxt = cts_pkg::M_PLUS;
              "-": mode_nxt = cts_pkg::M_MINUS;
              "*": mode_nxt = cts_pkg::M_AST;
              "%": mode_nxt = cts_pkg::M_PCT;
              "<": mode_nxt = cts_pkg::M_LT;
              ">": mode_nxt = cts_pkg::M_GT;
              "!": mode_nxt = cts_pkg::M_EXCL;
              "^": mode_nxt = cts_pkg::M_CARET;
              "&": mode_nxt = cts_pkg::M_AMP;
              "|": mode_nxt = cts_pkg::M_PIPE;
              "/": mode_nxt = cts_pkg::M_SLASH;
              8'h27: mode_nxt = cts_pkg::M_SQ;
              8'h22: mode_nxt = cts_pkg::M_DQ;
              "[": imm = cts_pkg::K_LBRACK;
              "]": imm = cts_pkg::K_RBRACK;
              "{": imm = cts_pkg::K_LBRACE;
              "}": imm = cts_pkg::K_RBRACE;
              "(": imm = cts_pkg::K_LPAREN;
              ")": imm = cts_pkg::K_RPAREN;
              ".": imm = cts_pkg::K_DOT;
              ";": imm = cts_pkg::K_SEMI;
              "~": imm = cts_pkg::K_TILDE;
              ",": imm = cts_pkg::K_COMMA;
              "?": imm = cts_pkg::K_QUEST;
              ":": imm = cts_pkg::K_COLON;
              default: imm = cts_pkg::K_ERR;
            endcase
            if (mode_nxt == cts_pkg::M_IDLE) begin
              r[n[0]].token_kind = imm;
              r[n[0]].token_start = pos_r;
              r[n[0]].token_length = 16'd1;
              r[n[0]].error_code = (imm == cts_pkg::K_ERR) ? cts_pkg::E_CHAR : cts_pkg::E_NONE;
              if (imm == cts_pkg::K_ERR) err_nxt = 1'b1;
              n = n + 2'd1;
            end
          end
        end
      end
    end
    if (n == 2'd2) r[1].last_of_run = 1'b1;
    else if (n == 2'd1) r[0].last_of_run = 1'b1;
    res0 = r[0];
    res1 = r[1];
    nres = n;
  end

  always_comb begin
    cnt_nxt = cnt_r - {1'b0, out_fire} + (in_fire ? nres : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cts_pkg::M_IDLE;
      kw_r <= '0;
      len_r <= '0;
      start_r <= '0;
      pos_r <= '0;
      err_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt;
        kw_r <= kw_nxt;
        len_r <= len_nxt;
        start_r <= start_nxt;
        pos_r <= pos_nxt;
        err_r <= err_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // result buffer, head in entry 0
  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r[0] <= res0;
      buf_r[1] <= res1;
    end else if (out_fire) buf_r[0] <= buf_r[1];
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("result buffer overflow");
  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == cts_pkg::K_END |-> out_data.last_of_run)
    else $error("end token not last");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.at_end |=> pos_r == 32'd0 && !err_r && mode_r == cts_pkg::M_IDLE)
    else $error("end marker did not clear state");
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != cts_pkg::E_NONE |-> out_data.token_kind == cts_pkg::K_ERR)
    else $error("error result with kind");

endmodule

/* verif/c_like_token_scanner_tb.sv */
`timescale 1ns / 1ps
module c_like_token_scanner_tb;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam logic [31:0] LEN_SAT = 32'h0000_ffff;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  cts_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  cts_pkg::out_beat_t out_data;

  c_like_token_scanner uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scanner shadow state
  cts_pkg::mode_t lex_mode;
  logic [7:0] lex_kwbuf [cts_pkg::KW_MAX];
  logic [31:0] lex_len;
  logic [31:0] lex_start;
  logic [31:0] lex_pos;
  logic lex_hold;
  cts_pkg::out_beat_t step_tokens [2];
  int step_count;

  cts_pkg::out_beat_t token_queue [$];
  int mismatches;
  int idle_cycles;
  logic stall_enable;

  function automatic logic alpha_c(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f || b[7];
  endfunction
  function automatic logic digit_c(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic hex_c(input logic [7:0] b);
    return digit_c(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction
  function automatic logic space_c(input logic [7:0] b);
    return b == 8'h20 || b == 8'h0a || b == 8'h0d || b == 8'h09 || b == 8'h0b;
  endfunction

  function automatic void push_token(input logic [6:0] k, input logic [31:0] s,
                                     input logic [31:0] l, input logic [2:0] e);
    if (step_count < 2) begin
      step_tokens[step_count].token_kind = k;
      step_tokens[step_count].token_start = s;
      step_tokens[step_count].token_length = (l > LEN_SAT) ? 16'hffff : l[15:0];
      step_tokens[step_count].error_code = e;
      step_tokens[step_count].last_of_run = 1'b0;
      step_count++;
    end
  endfunction

  function automatic void lengthen();
    if (lex_len < LEN_SAT) lex_len++;
  endfunction

  function automatic void close_as(input logic [6:0] k);
    push_token(k, lex_start, lex_len, cts_pkg::E_NONE);
    lex_mode = cts_pkg::M_IDLE;
  endfunction

  function automatic void abort_token(input logic [2:0] code, input logic with_byte);
    if (with_byte) lengthen();
    push_token(cts_pkg::K_ERR, lex_start, lex_len, code);
    lex_mode = cts_pkg::M_IDLE;
    lex_hold = 1'b1;
  endfunction

  function automatic void close_word();
    logic [6:0] k;
    logic hit;
    k = cts_pkg::K_IDENT;
    if (lex_len <= cts_pkg::KW_MAX) begin
      for (int i = 0; i < cts_pkg::NUM_KW; i++) begin
        hit = (cts_pkg::KW_LEN[i] == lex_len);
        for (int j = 0; j < cts_pkg::KW_MAX; j++)
          if (j < lex_len && lex_kwbuf[j] != cts_pkg::KW_TEXT[i][8*j +: 8]) hit = 1'b0;
        if (hit && k == cts_pkg::K_IDENT) k = cts_pkg::K_KW0 + 7'(i);
      end
    end
    close_as(k);
  endfunction

  task automatic start_token(input logic [7:0] b);
    logic [6:0] k;
    logic single;
    single = 1'b1;
    lex_start = lex_pos;
    lex_len = 32'd1;
    lex_mode = cts_pkg::M_IDLE;
    k = cts_pkg::K_ERR;
    if (space_c(b)) lex_mode = cts_pkg::M_SPACE;
    else if (alpha_c(b)) begin
      lex_mode = cts_pkg::M_IDENT;
      lex_kwbuf[0] = b;
    end else if (digit_c(b)) lex_mode = (b == 8'h30) ? cts_pkg::M_ZERO : cts_pkg::M_INT;
    else begin
      case (b)
        "=": lex_mode = cts_pkg::M_EQ;
        "+": lex_mode = cts_pkg::M_PLUS;
        "-": lex_mode = cts_pkg::M_MINUS;
        "*": lex_mode = cts_pkg::M_AST;
        "%": lex_mode = cts_pkg::M_PCT;
        "<": lex_mode = cts_pkg::M_LT;
        ">": lex_mode = cts_pkg::M_GT;
        "!": lex_mode = cts_pkg::M_EXCL;
        "^": lex_mode = cts_pkg::M_CARET;
        "&": lex_mode = cts_pkg::M_AMP;
        "|": lex_mode = cts_pkg::M_PIPE;
        "/": lex_mode = cts_pkg::M_SLASH;
        8'h27: lex_mode = cts_pkg::M_SQ;
        8'h22: lex_mode = cts_pkg::M_DQ;
        "[": k = cts_pkg::K_LBRACK;
        "]": k = cts_pkg::K_RBRACK;
        "{": k = cts_pkg::K_LBRACE;
        "}": k = cts_pkg::K_RBRACE;
        "(": k = cts_pkg::K_LPAREN;
        ")": k = cts_pkg::K_RPAREN;
        ".": k = cts_pkg::K_DOT;
        ";": k = cts_pkg::K_SEMI;
        "~": k = cts_pkg::K_TILDE;
        ",": k = cts_pkg::K_COMMA;
        "?": k = cts_pkg::K_QUEST;
        ":": k = cts_pkg::K_COLON;
        default: single = 1'b0;
      endcase
      if (lex_mode == cts_pkg::M_IDLE) begin
        if (single) push_token(k, lex_start, 32'd1, cts_pkg::E_NONE);
        else abort_token(cts_pkg::E_CHAR, 1'b0);
      end
    end
  endtask

  // returns 1 when the open token swallowed the byte
  function automatic logic extend_token(input logic [7:0] b);
    cts_pkg::mode_t m;
    logic e;
    m = lex_mode;
    e = (b == "e" || b == "E");
    if (m >= cts_pkg::M_EQ && m <= cts_pkg::M_EXCL) begin
      if ((m == cts_pkg::M_PLUS || m == cts_pkg::M_MINUS) && b == cts_pkg::op_dbl(m)) begin
        lengthen(); close_as(cts_pkg::op_dblk(m)); return 1'b1;
      end
      if (b == "=" && m != cts_pkg::M_EQ) begin
        lengthen(); close_as(cts_pkg::op_eqk(m)); return 1'b1;
      end
      if (b == "=") begin
        lengthen(); close_as(cts_pkg::K_EQEQ); return 1'b1;
      end
      close_as(cts_pkg::op_plain(m)); return 1'b0;
    end
    if (m >= cts_pkg::M_CARET && m <= cts_pkg::M_PIPE) begin
      if (b == cts_pkg::tr_ch(m)) begin
        lengthen(); lex_mode = cts_pkg::tr_next(m); return 1'b1;
      end
      if (b == "=") begin
        lengthen(); close_as(cts_pkg::op_eqk(m)); return 1'b1;
      end
      close_as(cts_pkg::op_plain(m)); return 1'b0;
    end
    if (m >= cts_pkg::M_CARET2 && m <= cts_pkg::M_PIPE2) begin
      if (b == "=") begin
        lengthen(); close_as(cts_pkg::op_eqk(m)); return 1'b1;
      end
      close_as(cts_pkg::op_plain(m)); return 1'b0;
    end
    case (m)
      cts_pkg::M_SPACE: begin
        if (space_c(b)) begin lengthen(); return 1'b1; end
        close_as(cts_pkg::K_WS); return 1'b0;
      end
      cts_pkg::M_IDENT: begin
        if (alpha_c(b) || digit_c(b)) begin
          if (lex_len < cts_pkg::KW_MAX) lex_kwbuf[lex_len] = b;
          lengthen(); return 1'b1;
        end
        close_word(); return 1'b0;
      end
      cts_pkg::M_ZERO, cts_pkg::M_INT: begin
        if (m == cts_pkg::M_ZERO && (b == "x" || b == "X")) begin
          lengthen(); lex_mode = cts_pkg::M_HEX0; return 1'b1;
        end
        if (digit_c(b)) begin lengthen(); lex_mode = cts_pkg::M_INT; return 1'b1; end
        if (b == ".") begin lengthen(); lex_mode = cts_pkg::M_FRAC; return 1'b1; end
        if (e) begin lengthen(); lex_mode = cts_pkg::M_EXP0; return 1'b1; end
        close_as(cts_pkg::K_UI); return 1'b0;
      end
      cts_pkg::M_FRAC: begin
        if (digit_c(b)) begin lengthen(); return 1'b1; end
        if (e) begin lengthen(); lex_mode = cts_pkg::M_EXP0; return 1'b1; end
        close_as(cts_pkg::K_FP); return 1'b0;
      end
      cts_pkg::M_EXP0, cts_pkg::M_EXPS: begin
        if (m == cts_pkg::M_EXP0 && (b == "+" || b == "-")) begin
          lengthen(); lex_mode = cts_pkg::M_EXPS; return 1'b1;
        end
        if (digit_c(b)) begin lengthen(); lex_mode = cts_pkg::M_EXPD; return 1'b1; end
        abort_token(cts_pkg::E_EXP, 1'b1); return 1'b1;
      end
      cts_pkg::M_EXPD: begin
        if (digit_c(b)) begin lengthen(); return 1'b1; end
        close_as(cts_pkg::K_FP); return 1'b0;
      end
      cts_pkg::M_HEX0: begin
        if (hex_c(b)) begin lengthen(); lex_mode = cts_pkg::M_HEXD; return 1'b1; end
        abort_token(cts_pkg::E_HEX, 1'b1); return 1'b1;
      end
      cts_pkg::M_HEXD: begin
        if (hex_c(b)) begin lengthen(); return 1'b1; end
        close_as(cts_pkg::K_UI); return 1'b0;
      end
      cts_pkg::M_SLASH: begin
        if (b == "=") begin lengthen(); close_as(cts_pkg::K_SLEQ); return 1'b1; end
        if (b == "*") begin lengthen(); lex_mode = cts_pkg::M_BLOCK; return 1'b1; end
        if (b == "/") begin lengthen(); lex_mode = cts_pkg::M_LINE; return 1'b1; end
        close_as(cts_pkg::K_SLASH); return 1'b0;
      end
      cts_pkg::M_LINE: begin
        if (b == 8'h0a) begin close_as(cts_pkg::K_LCOM); return 1'b0; end
        lengthen(); return 1'b1;
      end
      cts_pkg::M_BLOCK: begin
        lengthen();
        if (b == "*") lex_mode = cts_pkg::M_BSTAR;
        return 1'b1;
      end
      cts_pkg::M_BSTAR: begin
        if (b == "/") begin lengthen(); close_as(cts_pkg::K_BCOM); return 1'b1; end
        lengthen();
        lex_mode = (b == "*") ? cts_pkg::M_BSTAR : cts_pkg::M_BLOCK;
        return 1'b1;
      end
      cts_pkg::M_SQ, cts_pkg::M_DQ: begin
        if (b == 8'h5c) begin
          lengthen(); lex_mode = (m == cts_pkg::M_SQ) ? cts_pkg::M_SQE : cts_pkg::M_DQE;
          return 1'b1;
        end
        if (b == ((m == cts_pkg::M_SQ) ? 8'h27 : 8'h22)) begin
          lengthen(); close_as((m == cts_pkg::M_SQ) ? cts_pkg::K_SQS : cts_pkg::K_DQS);
          return 1'b1;
        end
        lengthen(); return 1'b1;
      end
      cts_pkg::M_SQE, cts_pkg::M_DQE: begin
        lengthen(); lex_mode = (m == cts_pkg::M_SQE) ? cts_pkg::M_SQ : cts_pkg::M_DQ;
        return 1'b1;
      end
      default: begin
        lex_mode = cts_pkg::M_IDLE; return 1'b0;
      end
    endcase
  endfunction

  task automatic flush_token();
    cts_pkg::mode_t m;
    m = lex_mode;
    if (m >= cts_pkg::M_EQ && m <= cts_pkg::M_PIPE2) close_as(cts_pkg::op_plain(m));
    else begin
      case (m)
        cts_pkg::M_SPACE: close_as(cts_pkg::K_WS);
        cts_pkg::M_IDENT: close_word();
        cts_pkg::M_ZERO, cts_pkg::M_INT, cts_pkg::M_HEXD: close_as(cts_pkg::K_UI);
        cts_pkg::M_FRAC, cts_pkg::M_EXPD: close_as(cts_pkg::K_FP);
        cts_pkg::M_EXP0, cts_pkg::M_EXPS: abort_token(cts_pkg::E_EXP, 1'b0);
        cts_pkg::M_HEX0: abort_token(cts_pkg::E_HEX, 1'b0);
        cts_pkg::M_SLASH: close_as(cts_pkg::K_SLASH);
        cts_pkg::M_LINE: close_as(cts_pkg::K_LCOM);
        cts_pkg::M_BLOCK, cts_pkg::M_BSTAR: abort_token(cts_pkg::E_COMMENT, 1'b0);
        cts_pkg::M_SQ, cts_pkg::M_SQE, cts_pkg::M_DQ, cts_pkg::M_DQE:
          abort_token(cts_pkg::E_STRING, 1'b0);
        default: ;
      endcase
    end
    lex_mode = cts_pkg::M_IDLE;
  endtask

  task automatic predict_tokens(input cts_pkg::in_beat_t beat);
    step_count = 0;
    if (beat.at_end) begin
      if (!lex_hold) flush_token();
      push_token(cts_pkg::K_END, lex_pos, 32'd0, cts_pkg::E_NONE);
      lex_pos = 0;
      lex_hold = 1'b0;
      lex_mode = cts_pkg::M_IDLE;
    end else begin
      if (!lex_hold) begin
        if (!extend_token(beat.data_byte)) start_token(beat.data_byte);
      end
      lex_pos++;
    end
    if (step_count > 0) step_tokens[step_count-1].last_of_run = 1'b1;
    for (int i = 0; i < step_count; i++) token_queue.push_back(step_tokens[i]);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result checker and stall driver
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (token_queue.size() == 0) report_mismatch("token with nothing expected");
      else begin
        cts_pkg::out_beat_t exp_tok;
        exp_tok = token_queue.pop_front();
        if (out_data.token_kind !== exp_tok.token_kind)
          report_mismatch($sformatf("kind %0d want %0d", out_data.token_kind,
                                    exp_tok.token_kind));
        if (out_data.token_start !== exp_tok.token_start)
          report_mismatch($sformatf("start %0d want %0d", out_data.token_start,
                                    exp_tok.token_start));
        if (out_data.token_length !== exp_tok.token_length)
          report_mismatch($sformatf("length %0d want %0d", out_data.token_length,
                                    exp_tok.token_length));
        if (out_data.error_code !== exp_tok.error_code)
          report_mismatch($sformatf("error %0d want %0d", out_data.error_code,
                                    exp_tok.error_code));
        if (out_data.last_of_run !== exp_tok.last_of_run)
          report_mismatch($sformatf("last %0d want %0d", out_data.last_of_run,
                                    exp_tok.last_of_run));
      end
    end
  end

  int stall_left;
  always @(negedge clk) begin
    if (!stall_enable) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = gap_len();
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    cts_pkg::in_beat_t beat;
    int g;
    g = stall_enable ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    beat.data_byte = b;
    beat.at_end = fin;
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_tokens(beat);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic end_run();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (token_queue.size() != 0) @(negedge clk);
  endtask

  task automatic test_operators();
    send_text("= == + += ++ - -= -- * *= / /= % %= ^ ^= ^^ ^^= & &= && &&= | |= || ||=");
    send_text(" [ ] { } ( ) . ; < <= > >= ~ ! != , ? :a+++b^^^c");
    end_run();
  endtask

  task automatic test_words_numbers();
    send_text("in io if do for var case else true alias break const false while struct ");
    send_text("switch report return default function operator continue functions _x9 ");
    send_text("\t\r\v\n 0 07 123 0x1fA 0XaB 1.5 2. 3e4 4E+5 6.7e-8 9x");
    send_beat(8'h80, 1'b0);
    send_beat(8'hff, 1'b0);
    end_run();
  endtask

  task automatic test_comments_strings();
    send_text("a// line\nb/* x ** y */c/**/'a\\'b'\"q\\\"z\"/x");
    end_run();
    send_text("x // open to the end");
    end_run();
  endtask

  task automatic test_errors();
    send_text("ab@cd"); end_run();
    send_text("0xg"); end_run();
    send_text("0x"); end_run();
    send_text("1e+q"); end_run();
    send_text("2e"); end_run();
    send_text("/* never"); end_run();
    send_text("\"open"); end_run();
    send_text("'esc\\"); end_run();
    end_run();
  endtask

  task automatic test_long_token();
    // long identifier, back to back, never a keyword
    stall_enable = 1'b0;
    send_beat("a", 1'b0);
    repeat (60) send_beat("b", 1'b0);
    send_beat(" ", 1'b0);
    end_run();
    stall_enable = 1'b1;
  endtask

  function automatic logic [7:0] pick_byte();
    string alphabet;
    int r;
    alphabet = "abcefinorstuxEX_019 .+-*/=<>!^&|%'\"\\\n[](){};,?:~";
    r = $urandom_range(0, 99);
    if (r < 8) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  task automatic test_random_text();
    string pieces [14];
    pieces = '{"while", "x1", "0x3f", "12.5e-3", "\"s\\n\"", "'c'", "/* c */",
                "// l\n", "&&=", "^^", " ", "\n", "continue", "7"};
    for (int n = 0; n < 12; n++) begin
      int len_run;
      len_run = $urandom_range(2, 20);
      for (int i = 0; i < len_run; i++) begin
        if ($urandom_range(0, 2) != 0) send_text(pieces[$urandom_range(0, 13)]);
        else send_beat(pick_byte(), 1'b0);
      end
      end_run();
      if (n == 6) drain_tokens();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    stall_enable = 1'b1;
    stall_left = 0;
    mismatches = 0;
    idle_cycles = 0;
    lex_mode = cts_pkg::M_IDLE;
    for (int i = 0; i < cts_pkg::KW_MAX; i++) lex_kwbuf[i] = 8'd0;
    lex_len = 0;
    lex_start = 0;
    lex_pos = 0;
    lex_hold = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_operators();
    test_words_numbers();
    test_comments_strings();
    test_errors();
    test_random_text();
    test_long_token();
    drain_tokens();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && token_queue.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
design/cts_pkg.sv
design/c_like_token_scanner.sv
verif/c_like_token_scanner_tb.sv
